[hw/rtl/joint_state_frame_receiver_core_defines.svh]
// ----------------------------------------------------------------------------
// Joint state frame receiver assertion macros
// Shared assertion shorthands, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef JOINT_STATE_FRAME_RECEIVER_CORE_DEFINES_SVH
`define JOINT_STATE_FRAME_RECEIVER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define JSFR_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define JSFR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/jsfr_pkg.sv]
// ----------------------------------------------------------------------------
// Joint state frame receiver package
// Register codes, reset values and shared types of the frame receiver.
// ----------------------------------------------------------------------------
package jsfr_pkg;

	localparam int ANGLE_W       = 16;
	localparam int REPORT_JOINTS = 4;
	localparam int CFG_DATA_W    = 9;
	localparam int LIMIT_W       = 9;

	localparam logic [ANGLE_W-1:0] HOME_DEG    = 16'd90;
	localparam logic [ANGLE_W-1:0] SKIP_MARKER = 16'hFFFF;

	localparam logic [7:0]         SYNC_RESET  = 8'hA5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd29;

	typedef enum logic [0:0] {
		REG_SYNC_VALUE = 1'b0,
		REG_JUMP_LIMIT = 1'b1
	} jsfr_reg_t;

	typedef struct packed {
		logic                     frame_good;
		logic [REPORT_JOINTS-1:0] update_mask;
	} jsfr_status_t;

endpackage

[hw/rtl/jsfr_fifo.sv]
// ----------------------------------------------------------------------------
// Joint state frame receiver queue
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
`include "joint_state_frame_receiver_core_defines.svh"

module jsfr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	`JSFR_ASSERT_NXT(a_full_holds, push && full && !pop, full, "Queue lost an entry while full.")

endmodule

[hw/rtl/jsfr_front.sv]
// ----------------------------------------------------------------------------
// Joint state frame receiver front end
// Hunts for the sync byte, collects angle bytes and checks the frame sum.
// ----------------------------------------------------------------------------
`include "joint_state_frame_receiver_core_defines.svh"

module jsfr_front #(
	parameter int NUM_JOINTS = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         byte_valid,
	input  logic [7:0]                   byte_data,
	input  logic [7:0]                   sync_value,
	input  logic                         frame_full,
	output logic                         frame_push,
	output logic                         frame_good,
	output logic [16*NUM_JOINTS-1:0]     frame_data
);

	localparam int FW = 16 * NUM_JOINTS;
	localparam int PW = $clog2(2 * NUM_JOINTS + 2);
	localparam logic [PW-1:0] LAST_POS = PW'(2 * NUM_JOINTS + 1);

	logic [PW-1:0] pos_q;
	logic [7:0]    sum_q;
	logic [FW-1:0] bytes_q;
	logic          accept;
	logic          data_phase;

	assign accept     = byte_valid && !frame_full;
	assign data_phase = (pos_q != '0) && (pos_q != LAST_POS);
	assign frame_push = accept && (pos_q == LAST_POS);
	assign frame_good = (sum_q == byte_data);
	assign frame_data = bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			sum_q <= '0;
		end else if (accept) begin
			priority if (pos_q == '0) begin
				if (byte_data == sync_value) begin
					pos_q <= PW'(1);
					sum_q <= '0;
				end
			end else if (pos_q == LAST_POS) begin
				pos_q <= '0;
				sum_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
				sum_q <= sum_q + byte_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && data_phase) begin
			bytes_q <= {byte_data, bytes_q[FW-1:8]};
		end
	end

	`JSFR_ASSERT_NXT(a_hunt_after_frame, frame_push, pos_q == '0, "Front did not return to hunting.")

endmodule

[hw/rtl/jsfr_back.sv]
// ----------------------------------------------------------------------------
// Joint state frame receiver back end
// Applies checked frames to the stored joint angles and queues the results.
// ----------------------------------------------------------------------------
`include "joint_state_frame_receiver_core_defines.svh"

module jsfr_back #(
	parameter int NUM_JOINTS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          frame_empty,
	input  logic                          frame_good,
	input  logic [16*NUM_JOINTS-1:0]      frame_data,
	output logic                          frame_pop,
	input  logic [jsfr_pkg::LIMIT_W-1:0]  jump_limit,
	input  logic                          res_pop,
	output logic                          res_empty,
	output logic                          res_good,
	output logic [3:0]                    res_mask,
	output logic signed [15:0]            res_angle_0,
	output logic signed [15:0]            res_angle_1,
	output logic signed [15:0]            res_angle_2,
	output logic signed [15:0]            res_angle_3
);

	localparam int FW = 16 * NUM_JOINTS;
	localparam int RJ = jsfr_pkg::REPORT_JOINTS;
	localparam int RW = $bits(jsfr_pkg::jsfr_status_t) + 16 * RJ;

	logic [FW-1:0]         angles_q;
	logic [FW-1:0]         next_angles;
	logic [NUM_JOINTS-1:0] upd_mask;
	logic [16*RJ-1:0]      rep_angles;
	logic [RJ-1:0]         rep_mask;
	jsfr_pkg::jsfr_status_t status;
	logic                  res_full;
	logic                  take;
	logic [RW-1:0]         res_wdata;
	logic [RW-1:0]         res_rdata;

	assign take      = !frame_empty && !res_full;
	assign frame_pop = take;

	for (genvar j = 0; j < NUM_JOINTS; j++) begin : g_joint
		logic [15:0] nv;
		logic [15:0] cur;
		logic [16:0] diff;
		logic [16:0] absd;
		logic        too_far;

		assign nv      = frame_data[16*j +: 16];
		assign cur     = angles_q[16*j +: 16];
		assign diff    = {nv[15], nv} - {cur[15], cur};
		assign absd    = diff[16] ? (17'd0 - diff) : diff;
		assign too_far = (absd > 17'(jump_limit)) && (cur != jsfr_pkg::HOME_DEG);
		assign upd_mask[j] = frame_good && (nv != jsfr_pkg::SKIP_MARKER) && !too_far;
		assign next_angles[16*j +: 16] = upd_mask[j] ? nv : cur;
	end

	for (genvar k = 0; k < RJ; k++) begin : g_report
		if (k < NUM_JOINTS) begin : g_live
			assign rep_angles[16*k +: 16] = next_angles[16*k +: 16];
			assign rep_mask[k]            = upd_mask[k];
		end else begin : g_absent
			assign rep_angles[16*k +: 16] = '0;
			assign rep_mask[k]            = 1'b0;
		end
	end

	assign status.frame_good  = frame_good;
	assign status.update_mask = rep_mask;
	assign res_wdata          = {status, rep_angles};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angles_q <= {NUM_JOINTS{jsfr_pkg::HOME_DEG}};
		end else if (take) begin
			angles_q <= next_angles;
		end
	end

	jsfr_fifo #(
		.WIDTH(RW),
		.DEPTH(2)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (take),
		.full  (res_full),
		.wdata (res_wdata),
		.pop   (res_pop),
		.empty (res_empty),
		.rdata (res_rdata)
	);

	assign res_good    = res_rdata[RW-1];
	assign res_mask    = res_rdata[RW-2 -: 4];
	assign res_angle_0 = res_rdata[15:0];
	assign res_angle_1 = res_rdata[31:16];
	assign res_angle_2 = res_rdata[47:32];
	assign res_angle_3 = res_rdata[63:48];

	`JSFR_ASSERT_NXT(a_bad_keeps_angles, take && !frame_good, $stable(angles_q), "Bad frame changed angles.")
	`JSFR_ASSERT_IMP(a_bad_no_mask, take && !frame_good, upd_mask == '0, "Bad frame set mask bits.")

endmodule

[hw/rtl/joint_state_frame_receiver_core.sv]
// ----------------------------------------------------------------------------
// Joint state frame receiver core
// Parses sync-framed joint angle packets from a serial byte stream.
//
// Bytes enter on rx_byte through push/full. A frame is a sync byte, two
// little-endian bytes per joint and a checksum byte. Each completed frame
// gives one result word on the output side through empty/pop: frame_good,
// update_mask and the stored angles after the frame.
// One word is taken every cycle while full is low; full rises only when
// the frame queue between the parser and the update stage is full, which
// happens when results are not popped. The result for a frame goes through
// the frame queue, the update stage and the result queue once its checksum
// byte is accepted. Configuration writes on cfg_write/cfg_index/cfg_data
// take effect at the next edge. Reset returns the parser to hunting, empties
// both queues, sets every angle to 90 degrees and loads the register
// defaults. When the receiver stalls, results wait in a two-entry queue,
// then frames back up in a two-entry queue before full is raised.
// ----------------------------------------------------------------------------
module joint_state_frame_receiver_core #(
	parameter int NUM_JOINTS = 4
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [7:0]                       rx_byte,
	output logic                             empty,
	input  logic                             pop,
	output logic                             frame_good,
	output logic [3:0]                       update_mask,
	output logic signed [15:0]               angle_0,
	output logic signed [15:0]               angle_1,
	output logic signed [15:0]               angle_2,
	output logic signed [15:0]               angle_3,
	input  logic                             cfg_write,
	input  logic [0:0]                       cfg_index,
	input  logic [jsfr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int FW = 16 * NUM_JOINTS;
	localparam int QW = FW + 1;

	logic [7:0]                  sync_value_q;
	logic [jsfr_pkg::LIMIT_W-1:0] jump_limit_q;
	logic                        fq_push;
	logic                        fq_full;
	logic                        fq_empty;
	logic                        fq_pop;
	logic                        front_good;
	logic [FW-1:0]               front_data;
	logic [QW-1:0]               fq_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_value_q <= jsfr_pkg::SYNC_RESET;
			jump_limit_q <= jsfr_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			unique case (jsfr_pkg::jsfr_reg_t'(cfg_index))
				jsfr_pkg::REG_SYNC_VALUE: sync_value_q <= cfg_data[7:0];
				jsfr_pkg::REG_JUMP_LIMIT: jump_limit_q <= cfg_data[jsfr_pkg::LIMIT_W-1:0];
			endcase
		end
	end

	assign full = fq_full;

	jsfr_front #(
		.NUM_JOINTS(NUM_JOINTS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(push),
		.byte_data (rx_byte),
		.sync_value(sync_value_q),
		.frame_full(fq_full),
		.frame_push(fq_push),
		.frame_good(front_good),
		.frame_data(front_data)
	);

	jsfr_fifo #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_frame_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fq_push),
		.full  (fq_full),
		.wdata ({front_good, front_data}),
		.pop   (fq_pop),
		.empty (fq_empty),
		.rdata (fq_rdata)
	);

	jsfr_back #(
		.NUM_JOINTS(NUM_JOINTS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_empty(fq_empty),
		.frame_good (fq_rdata[QW-1]),
		.frame_data (fq_rdata[FW-1:0]),
		.frame_pop  (fq_pop),
		.jump_limit (jump_limit_q),
		.res_pop    (pop),
		.res_empty  (empty),
		.res_good   (frame_good),
		.res_mask   (update_mask),
		.res_angle_0(angle_0),
		.res_angle_1(angle_1),
		.res_angle_2(angle_2),
		.res_angle_3(angle_3)
	);

endmodule

[test/jsfr_frame_checker.sv]
// ----------------------------------------------------------------------------
// Joint state frame receiver checker
// Watches the byte, result and register channels of the frame receiver,
// predicts the result of every completed frame and compares each popped word
// against the oldest prediction.
// ----------------------------------------------------------------------------
module jsfr_frame_checker (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic                    full,
	input  logic [7:0]              rx_byte,
	input  logic                    empty,
	input  logic                    pop,
	input  logic                    frame_good,
	input  logic [3:0]              update_mask,
	input  logic signed [15:0]      angle_0,
	input  logic signed [15:0]      angle_1,
	input  logic signed [15:0]      angle_2,
	input  logic signed [15:0]      angle_3,
	input  logic                    cfg_write,
	input  logic [0:0]              cfg_index,
	input  logic [jsfr_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                      mismatches,
	output int                      waiting,
	output int                      checked,
	output logic [3:0][15:0]        joint_now
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             good;
		logic [3:0]       mask;
		logic [3:0][15:0] angle;
	} frame_report_t;

	frame_report_t          reports_due[$];
	logic [7:0]             sync_byte;
	logic [jsfr_pkg::LIMIT_W-1:0] jump_limit;
	int unsigned            byte_pos;
	logic [7:0]             held [8];
	logic [7:0]             byte_sum;
	logic [3:0][15:0]       stored;

	assign joint_now = stored;

	function automatic bit parse_byte(input logic [7:0] b, output frame_report_t rep);
		logic signed [15:0] nv;
		int                 diff;
		rep = '0;
		if (byte_pos == 0) begin
			if (b == sync_byte) begin
				byte_pos = 1;
				byte_sum = 8'd0;
			end
			return 1'b0;
		end
		if (byte_pos <= 2 * jsfr_pkg::REPORT_JOINTS) begin
			held[byte_pos - 1] = b;
			byte_sum = byte_sum + b;
			byte_pos++;
			return 1'b0;
		end
		rep.good = (byte_sum == b);
		if (rep.good) begin
			for (int j = 0; j < jsfr_pkg::REPORT_JOINTS; j++) begin
				nv = {held[2 * j + 1], held[2 * j]};
				diff = int'(nv) - int'($signed(stored[j]));
				if (diff < 0)
					diff = -diff;
				if (nv != jsfr_pkg::SKIP_MARKER &&
				    !(diff > int'(jump_limit) && stored[j] != jsfr_pkg::HOME_DEG)) begin
					stored[j] = nv;
					rep.mask[j] = 1'b1;
				end
			end
		end
		byte_pos = 0;
		byte_sum = 8'd0;
		rep.angle = stored;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		frame_report_t rep;
		frame_report_t seen;
		frame_report_t want;
		bit            bad;
		if (!arst_n) begin
			sync_byte = jsfr_pkg::SYNC_RESET;
			jump_limit = jsfr_pkg::LIMIT_RESET;
			byte_pos = 0;
			byte_sum = 8'd0;
			stored = {jsfr_pkg::REPORT_JOINTS{jsfr_pkg::HOME_DEG}};
			reports_due.delete();
			mismatches = 0;
			waiting = 0;
			checked = 0;
		end else begin
			if (cfg_write) begin
				case (jsfr_pkg::jsfr_reg_t'(cfg_index))
					jsfr_pkg::REG_SYNC_VALUE: sync_byte = cfg_data[7:0];
					jsfr_pkg::REG_JUMP_LIMIT: jump_limit = cfg_data[jsfr_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (push && !full) begin
				if (parse_byte(rx_byte, rep))
					reports_due.push_back(rep);
			end
			if (pop && !empty) begin
				seen = {frame_good, update_mask, angle_3, angle_2, angle_1, angle_0};
				checked++;
				if (reports_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result word: good=%0b mask=%b angles %0d %0d %0d %0d",
							seen.good, seen.mask, angle_0, angle_1, angle_2, angle_3);
				end else begin
					want = reports_due.pop_front();
					bad = (seen.good !== want.good) || (seen.mask !== want.mask);
					for (int j = 0; j < jsfr_pkg::REPORT_JOINTS; j++)
						bad = bad || (seen.angle[j] !== want.angle[j]);
					if (bad) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("Result %0d differs: expected good=%0b mask=%b angles %0d %0d %0d %0d",
								checked, want.good, want.mask,
								$signed(want.angle[0]), $signed(want.angle[1]),
								$signed(want.angle[2]), $signed(want.angle[3]));
							$display("  got good=%0b mask=%b angles %0d %0d %0d %0d",
								seen.good, seen.mask, angle_0, angle_1, angle_2, angle_3);
						end
					end
				end
			end
			waiting = reports_due.size();
		end
	end

endmodule

[test/joint_state_frame_receiver_core_tb.sv]
// ----------------------------------------------------------------------------
// Joint state frame receiver core testbench
// Feeds sync-framed joint angle packets, noise bytes and corrupted frames
// into the receiver under several register settings and flow-control
// patterns, while a checker beside the core predicts and compares results.
// ----------------------------------------------------------------------------
module joint_state_frame_receiver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES           = 6;
	localparam int FRAMES_PER_PHASE = 22;
	localparam int LONG_HOLD        = 300;
	localparam int HOLD_PHASE       = 4;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    push;
	logic                    full;
	logic [7:0]              rx_byte;
	logic                    empty;
	logic                    pop;
	logic                    frame_good;
	logic [3:0]              update_mask;
	logic signed [15:0]      angle_0;
	logic signed [15:0]      angle_1;
	logic signed [15:0]      angle_2;
	logic signed [15:0]      angle_3;
	logic                    cfg_write;
	logic [0:0]              cfg_index;
	logic [jsfr_pkg::CFG_DATA_W-1:0] cfg_data;

	int                      mismatches;
	int                      waiting;
	int                      checked;
	logic [3:0][15:0]        joint_now;

	int                      send_gap_pct;
	int                      pop_stall_pct;
	int                      hold_token;
	logic [7:0]              cur_sync;
	logic [jsfr_pkg::LIMIT_W-1:0] cur_limit;
	int                      frames;
	int                      good_frames;
	int                      noise_bytes;

	always #4 clk = ~clk;

	joint_state_frame_receiver_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.frame_good  (frame_good),
		.update_mask (update_mask),
		.angle_0     (angle_0),
		.angle_1     (angle_1),
		.angle_2     (angle_2),
		.angle_3     (angle_3),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	jsfr_frame_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.frame_good  (frame_good),
		.update_mask (update_mask),
		.angle_0     (angle_0),
		.angle_1     (angle_1),
		.angle_2     (angle_2),
		.angle_3     (angle_3),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.waiting     (waiting),
		.checked     (checked),
		.joint_now   (joint_now)
	);

	// The receiver pops at random, except during a requested long hold-off.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_token != hold_seen) begin
				hold_seen = hold_token;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= pop_stall_pct);
			end
		end
	end

	initial begin
		#1_000_000;
		$display("Some tests failed");
		$finish;
	end

	// A word is taken at an edge where push is high and full is low.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_gap_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_noise();
		logic [7:0] b;
		b = 8'($urandom());
		if (b == cur_sync)
			b ^= 8'h01;
		send_byte(b);
		noise_bytes++;
	endtask

	task automatic send_frame(input logic [3:0][15:0] ang, input bit good_sum,
		input bit sync_inside);
		logic [7:0] fb [8];
		logic [7:0] sum;
		for (int j = 0; j < jsfr_pkg::REPORT_JOINTS; j++) begin
			fb[2 * j] = ang[j][7:0];
			fb[2 * j + 1] = ang[j][15:8];
		end
		if (sync_inside)
			fb[$urandom_range(7)] = cur_sync;
		sum = 8'd0;
		for (int i = 0; i < 8; i++)
			sum += fb[i];
		send_byte(cur_sync);
		for (int i = 0; i < 8; i++)
			send_byte(fb[i]);
		send_byte(good_sum ? sum : sum ^ 8'($urandom_range(1, 255)));
		frames++;
		if (good_sum)
			good_frames++;
	endtask

	function automatic logic [15:0] pick_angle(input logic [15:0] now, input int lim);
		int base;
		int dir;
		base = int'($signed(now));
		dir = $urandom_range(1) ? 1 : -1;
		case ($urandom_range(9))
			0: return jsfr_pkg::SKIP_MARKER;
			1: return jsfr_pkg::HOME_DEG;
			2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			3: return 16'($urandom());
			4: return 16'(base + dir * (lim + 1));
			5: return 16'(base + dir * lim);
			default: return 16'(base + int'($urandom_range(2 * lim)) - lim);
		endcase
	endfunction

	task automatic write_reg(input jsfr_pkg::jsfr_reg_t idx,
		input logic [jsfr_pkg::CFG_DATA_W-1:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_write <= 1'b1;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain_block();
		push <= 1'b0;
		wait (waiting == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode)
			1: begin
				send_gap_pct = 71;
				pop_stall_pct = 0;
			end
			2: begin
				send_gap_pct = 0;
				pop_stall_pct = 71;
			end
			3: begin
				send_gap_pct = 25;
				pop_stall_pct = 25;
			end
			default: begin
				send_gap_pct = 0;
				pop_stall_pct = 0;
			end
		endcase
	endtask

	initial begin
		logic [3:0][15:0] ang;
		push = 1'b0;
		rx_byte = 8'd0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		send_gap_pct = 0;
		pop_stall_pct = 0;
		hold_token = 0;
		cur_sync = jsfr_pkg::SYNC_RESET;
		cur_limit = jsfr_pkg::LIMIT_RESET;
		frames = 0;
		good_frames = 0;
		noise_bytes = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_noise();
		send_frame({jsfr_pkg::HOME_DEG, jsfr_pkg::SKIP_MARKER, 16'h8000, 16'h7FFF},
			1'b1, 1'b0);
		send_frame({16'h1234, 16'hFFFE, 16'h0001, 16'h005A}, 1'b0, 1'b1);
		send_frame({jsfr_pkg::SKIP_MARKER, jsfr_pkg::HOME_DEG, 16'h801D, 16'h7FE1},
			1'b1, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain_block();
				case (p)
					1: begin
						cur_sync = 8'h00;
						cur_limit = 9'd0;
					end
					2: begin
						cur_sync = 8'hFF;
						cur_limit = 9'd360;
					end
					3: begin
						cur_sync = 8'h3C;
						cur_limit = 9'd511;
					end
					HOLD_PHASE: begin
						cur_sync = 8'($urandom());
						cur_limit = 9'($urandom_range(360));
					end
					default: begin
						cur_sync = jsfr_pkg::SYNC_RESET;
						cur_limit = jsfr_pkg::LIMIT_RESET;
					end
				endcase
				write_reg(jsfr_pkg::REG_SYNC_VALUE, {1'b0, cur_sync});
				write_reg(jsfr_pkg::REG_JUMP_LIMIT, cur_limit);
			end
			set_idling(p % 4);
			if (p == HOLD_PHASE)
				hold_token++;
			for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
				if ($urandom_range(3) == 0)
					repeat ($urandom_range(1, 3)) send_noise();
				for (int j = 0; j < jsfr_pkg::REPORT_JOINTS; j++)
					ang[j] = pick_angle(joint_now[j], int'(cur_limit));
				send_frame(ang, $urandom_range(99) < 85, $urandom_range(9) == 0);
			end
		end

		push <= 1'b0;
		send_gap_pct = 0;
		pop_stall_pct = 0;
		wait (waiting == 0);
		repeat (10) @(negedge clk);

		$display("Covered %0d frames (%0d with a good checksum) and %0d ignored bytes",
			frames, good_frames, noise_bytes);
		$display("under %0d register settings and four flow-control patterns; %0d results checked",
			PHASES, checked);
		if (mismatches == 0 && waiting == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/jsfr_pkg.sv
hw/rtl/jsfr_fifo.sv
hw/rtl/jsfr_front.sv
hw/rtl/jsfr_back.sv
hw/rtl/joint_state_frame_receiver_core.sv
test/jsfr_frame_checker.sv
test/joint_state_frame_receiver_core_tb.sv
